// ----- design/tmss_pkg.sv -----
// Shared types and constants for the trimmed-mean sensor scaler.
package tmss_pkg;

	localparam int ADC_W = 10;
	localparam int VAL_W = 16;
	localparam int NUM_W = 28;
	localparam int DEN_W = 10;
	localparam int STEP_W = $clog2(NUM_W);

	typedef enum logic [1:0] {
		REG_ADC_LOW   = 2'd0,
		REG_ADC_HIGH  = 2'd1,
		REG_VALUE_LOW = 2'd2,
		REG_VALUE_HIGH = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TRIM,
		ST_DIV_MEAN,
		ST_MUL,
		ST_SIGN,
		ST_DIV_SCALE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

// ----- design/tmss_div.sv -----
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
module tmss_div import tmss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ----- design/trimmed_mean_sensor_scaler_top.sv -----
// Top level of the trimmed-mean sensor scaler: ring, sequencer, scaling, APB registers.
//
// Each accepted sample is written into a ring of DEPTH entries, then the ring is
// scanned once (one entry per cycle) for the first maximum, the first minimum and
// the total. The trimmed mean and the linear scaling both run through one shared
// 28-step serial divider, and the scaling divide is skipped when adc_high equals
// adc_low. s_tready is low from acceptance until the sequencer is back in idle, so
// no new sample is taken while an item is in work. A finished result waits in the
// output register while the next sample may already be taken.
// scale_error in m_tuser is set, with scaled_value 0, when adc_high equals adc_low.
module trimmed_mean_sensor_scaler_top import tmss_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] adc_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [9:0] trimmed_mean, [25:10] scaled_value
	output logic [0:0]  m_tuser,   // [0] scale_error
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int SUM_W = ADC_W + $clog2(DEPTH);

	logic [ADC_W-1:0] adc_low_q, adc_high_q;
	logic signed [VAL_W-1:0] value_low_q, value_high_q;

	logic [ADC_W-1:0] ring_q [DEPTH];
	logic [IDX_W-1:0] wp_q, wp_next;
	logic [IDX_W-1:0] idx_q, imax_q, imin_q;
	logic [ADC_W-1:0] vmax_q, vmin_q, cur;
	logic [SUM_W-1:0] total_q, trim_sum;
	logic [DEN_W-1:0] trim_cnt;
	logic [ADC_W-1:0] mean_q;
	logic signed [NUM_W-1:0] prod_q, prod_c;
	logic [NUM_W-1:0] qmag_q;
	logic             neg_q;

	state_t   state_q, state_d;
	div_req_t req;
	div_rsp_t rsp;

	logic cfg_wr, in_acc, out_free, err;
	logic signed [VAL_W:0]   dv;
	logic signed [ADC_W:0]   dm, den_s;
	logic signed [NUM_W:0]   q_s;
	logic signed [NUM_W+1:0] sum_s;
	logic signed [VAL_W-1:0] scaled;

	logic [ADC_W-1:0]       m_mean_q;
	logic signed [VAL_W-1:0] m_scaled_q;
	logic                   m_err_q, m_tvalid_q;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_low_q    <= '0;
			adc_high_q   <= '1;
			value_low_q  <= '0;
			value_high_q <= VAL_W'(1000);
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_ADC_LOW:    adc_low_q    <= pwdata[ADC_W-1:0];
				REG_ADC_HIGH:   adc_high_q   <= pwdata[ADC_W-1:0];
				REG_VALUE_LOW:  value_low_q  <= pwdata[VAL_W-1:0];
				REG_VALUE_HIGH: value_high_q <= pwdata[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_ADC_LOW:    prdata = 32'(adc_low_q);
			REG_ADC_HIGH:   prdata = 32'(adc_high_q);
			REG_VALUE_LOW:  prdata = 32'(value_low_q);
			REG_VALUE_HIGH: prdata = 32'(value_high_q);
			default:        prdata = '0;
		endcase
	end

	// sample ring
	assign in_acc  = s_tvalid && s_tready;
	assign wp_next = (wp_q == IDX_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			for (int i = 0; i < DEPTH; i++) ring_q[i] <= '0;
		end else if (in_acc) begin
			wp_q           <= wp_next;
			ring_q[wp_next] <= s_tdata[ADC_W-1:0];
		end
	end

	assign cur = ring_q[idx_q];

	// arithmetic helpers
	assign err      = adc_high_q == adc_low_q;
	assign trim_sum = total_q - SUM_W'(vmax_q) - ((imax_q == imin_q) ? '0 : SUM_W'(vmin_q));
	assign trim_cnt = (imax_q == imin_q) ? DEN_W'(DEPTH - 1) : DEN_W'(DEPTH - 2);
	assign dv       = (VAL_W+1)'(value_high_q) - (VAL_W+1)'(value_low_q);
	assign dm       = $signed({1'b0, mean_q}) - $signed({1'b0, adc_low_q});
	assign den_s    = $signed({1'b0, adc_high_q}) - $signed({1'b0, adc_low_q});
	assign prod_c   = dv * dm;
	assign q_s      = neg_q ? -$signed({1'b0, qmag_q}) : $signed({1'b0, qmag_q});
	assign sum_s    = (NUM_W+2)'(q_s) + (NUM_W+2)'(value_low_q);

	always_comb begin
		if (err)
			scaled = '0;
		else if (sum_s > (NUM_W+2)'(32767))
			scaled = 16'sh7fff;
		else if (sum_s < -(NUM_W+2)'(32768))
			scaled = 16'sh8000;
		else
			scaled = sum_s[VAL_W-1:0];
	end

	assign out_free = !m_tvalid_q || m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		req.start = 1'b0;
		req.num   = NUM_W'(trim_sum);
		req.den   = trim_cnt;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (idx_q == IDX_W'(DEPTH - 1)) state_d = ST_TRIM;
			end
			ST_TRIM: begin
				req.start = 1'b1;
				state_d   = ST_DIV_MEAN;
			end
			ST_DIV_MEAN: begin
				if (rsp.done) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = err ? ST_OUT : ST_SIGN;
			end
			ST_SIGN: begin
				req.start = 1'b1;
				req.num   = prod_q[NUM_W-1] ? NUM_W'(-prod_q) : NUM_W'(prod_q);
				req.den   = den_s[ADC_W] ? DEN_W'(-den_s) : DEN_W'(den_s);
				state_d   = ST_DIV_SCALE;
			end
			ST_DIV_SCALE: begin
				if (rsp.done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	tmss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) idx_q <= '0;
		if (state_q == ST_SCAN) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == '0) begin
				vmax_q  <= cur;
				vmin_q  <= cur;
				imax_q  <= '0;
				imin_q  <= '0;
				total_q <= SUM_W'(cur);
			end else begin
				total_q <= total_q + SUM_W'(cur);
				if (cur > vmax_q) begin
					vmax_q <= cur;
					imax_q <= idx_q;
				end
				if (cur < vmin_q) begin
					vmin_q <= cur;
					imin_q <= idx_q;
				end
			end
		end
		if (state_q == ST_DIV_MEAN && rsp.done) mean_q <= rsp.quo[ADC_W-1:0];
		if (state_q == ST_MUL) prod_q <= prod_c;
		if (state_q == ST_SIGN) neg_q <= prod_q[NUM_W-1] ^ den_s[ADC_W];
		if (state_q == ST_DIV_SCALE && rsp.done) qmag_q <= rsp.quo;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_mean_q   <= mean_q;
			m_scaled_q <= scaled;
			m_err_q    <= err;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, m_scaled_q, m_mean_q};
	assign m_tuser  = m_err_q;

`ifndef SYNTHESIS
	a_acc_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_SCAN)
		else $error("accepted item did not start a scan");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_DIV_MEAN || state_q == ST_DIV_SCALE))
		else $error("divider finished outside a divide state");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> m_tvalid)
		else $error("finished result not offered");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tdata[25:10] == 16'h0000)
		else $error("scale error with nonzero value");
`endif

endmodule

// ----- test/tb_top.sv -----
// Testbench for the trimmed-mean sensor scaler: streamed samples checked against a local predictor.
`timescale 1ns / 1ps

module tb_top;
	import tmss_pkg::*;

	localparam int DEPTH = 8;
	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		logic [ADC_W-1:0] mean;
		logic [VAL_W-1:0] scaled;
		logic             err;
	} reading_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [9:0] adc_sample
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [9:0] trimmed_mean, [25:10] scaled_value
	logic [0:0]  m_tuser;   // [0] scale_error
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	trimmed_mean_sensor_scaler_top #(.DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the window and the scaling registers
	logic [ADC_W-1:0]        win_ring [DEPTH];
	int                      win_ptr;
	logic [ADC_W-1:0]        cfg_adc_low;
	logic [ADC_W-1:0]        cfg_adc_high;
	logic signed [VAL_W-1:0] cfg_val_low;
	logic signed [VAL_W-1:0] cfg_val_high;

	logic [15:0] sample_q [$];
	reading_t    reading_q [$];
	int          mismatch_count;

	int burst_left;
	int gap_left;
	int stall_left;
	int rx_cycle;
	int quiet_cycles;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic reading_t next_reading(input logic [ADC_W-1:0] sample);
		int unsigned hi_idx, lo_idx, total, cnt;
		logic [ADC_W-1:0] hi_val, lo_val;
		longint num, den, q;
		reading_t r;
		win_ptr = (win_ptr == DEPTH - 1) ? 0 : win_ptr + 1;
		win_ring[win_ptr] = sample;
		hi_idx = 0;
		lo_idx = 0;
		hi_val = win_ring[0];
		lo_val = win_ring[0];
		for (int i = 1; i < DEPTH; i++) begin
			if (win_ring[i] > hi_val) begin
				hi_val = win_ring[i];
				hi_idx = i;
			end
			if (win_ring[i] < lo_val) begin
				lo_val = win_ring[i];
				lo_idx = i;
			end
		end
		total = 0;
		cnt = 0;
		for (int i = 0; i < DEPTH; i++) begin
			if (i != hi_idx && i != lo_idx) begin
				total += win_ring[i];
				cnt++;
			end
		end
		r.mean = ADC_W'(total / cnt);
		if (cfg_adc_high == cfg_adc_low) begin
			r.err = 1'b1;
			r.scaled = '0;
		end else begin
			r.err = 1'b0;
			num = (longint'(cfg_val_high) - longint'(cfg_val_low))
			    * (longint'({1'b0, r.mean}) - longint'({1'b0, cfg_adc_low}));
			den = longint'({1'b0, cfg_adc_high}) - longint'({1'b0, cfg_adc_low});
			q = num / den + longint'(cfg_val_low);
			if (q > 32767)
				q = 32767;
			if (q < -32768)
				q = -32768;
			r.scaled = VAL_W'(q);
		end
		return r;
	endfunction

	// stream sender: bursts of items separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (s_tvalid)
					reading_q.push_back(next_reading(s_tdata[ADC_W-1:0]));
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= sample_q.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						case ($urandom_range(0, 9))
							0, 1, 2: gap_left <= 0;
							3, 4, 5, 6: gap_left <= $urandom_range(1, 80);
							default: gap_left <= $urandom_range(1, 10);
						endcase
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result receiver and checker; stall behavior changes with bits [10:9] of rx_cycle
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			rx_cycle <= rx_cycle + 1;
			if (m_tvalid && m_tready) begin
				if (reading_q.size() == 0) begin
					$error("unexpected result: tdata %h tuser %h", m_tdata, m_tuser);
					mismatch_count++;
				end else begin
					want = reading_q.pop_front();
					if (m_tdata[9:0] !== want.mean) begin
						$error("trimmed_mean: expected %0d, actual %0d", want.mean, m_tdata[9:0]);
						mismatch_count++;
					end
					if (m_tdata[25:10] !== want.scaled) begin
						$error("scaled_value: expected %0d, actual %0d",
							$signed(want.scaled), $signed(m_tdata[25:10]));
						mismatch_count++;
					end
					if (m_tuser[0] !== want.err) begin
						$error("scale_error: expected %0d, actual %0d", want.err, m_tuser[0]);
						mismatch_count++;
					end
				end
			end
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				m_tready <= 1'b1;
				case (rx_cycle[10:9])
					2'd1: if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 4);
					2'd2: if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(20, 120);
					2'd3: if ($urandom_range(0, 1) == 0) stall_left <= $urandom_range(1, 8);
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic cfg_write(input reg_idx_t idx, input logic [15:0] val);
		logic [31:0] data;
		data = $urandom;
		if (idx == REG_ADC_LOW || idx == REG_ADC_HIGH)
			data[ADC_W-1:0] = val[ADC_W-1:0];
		else
			data[VAL_W-1:0] = val;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ADC_LOW: cfg_adc_low = data[ADC_W-1:0];
			REG_ADC_HIGH: cfg_adc_high = data[ADC_W-1:0];
			REG_VALUE_LOW: cfg_val_low = data[VAL_W-1:0];
			REG_VALUE_HIGH: cfg_val_high = data[VAL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_scaling(input int al, input int ah, input int vl, input int vh);
		cfg_write(REG_ADC_LOW, 16'(al));
		cfg_write(REG_ADC_HIGH, 16'(ah));
		cfg_write(REG_VALUE_LOW, 16'(vl));
		cfg_write(REG_VALUE_HIGH, 16'(vh));
	endtask

	task automatic push_sample(input int v);
		logic [15:0] w;
		w = $urandom;
		w[ADC_W-1:0] = v[ADC_W-1:0];
		sample_q.push_back(w);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		while (sample_q.size() != 0 || reading_q.size() != 0 || s_tvalid)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_scaling(input int kind);
		int al, ah, vl, vh;
		case (kind)
			0: begin
				al = $urandom_range(0, 1023);
				ah = $urandom_range(0, 1023);
				vl = $urandom_range(0, 65535);
				vh = $urandom_range(0, 65535);
			end
			1: begin
				al = $urandom_range(0, 1) ? 1023 : 0;
				ah = 1023 - al;
				vl = $urandom_range(0, 1) ? -32768 : 32767;
				vh = $urandom_range(0, 1) ? -32768 : 32767;
			end
			2: begin
				al = $urandom_range(0, 1023);
				ah = al;
				vl = $urandom_range(0, 65535);
				vh = $urandom_range(0, 65535);
			end
			3: begin
				al = $urandom_range(0, 1020);
				ah = al + $urandom_range(1, 3);
				vl = $urandom_range(0, 65535);
				vh = $urandom_range(0, 65535);
			end
			4: begin
				al = $urandom_range(0, 100);
				ah = $urandom_range(900, 1023);
				vl = int'($urandom_range(0, 200)) - 100;
				vh = $urandom_range(500, 5000);
			end
			default: begin
				ah = $urandom_range(0, 100);
				al = $urandom_range(900, 1023);
				vl = $urandom_range(0, 2000);
				vh = -int'($urandom_range(0, 2000));
			end
		endcase
		set_scaling(al, ah, vl, vh);
	endtask

	initial begin
		int base, last, v;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < DEPTH; i++)
			win_ring[i] = '0;
		win_ptr = 0;
		cfg_adc_low = 10'd0;
		cfg_adc_high = 10'd1023;
		cfg_val_low = 16'sd0;
		cfg_val_high = 16'sd1000;
		mismatch_count = 0;
		burst_left = 1;
		gap_left = 0;
		stall_left = 0;
		rx_cycle = 0;
		quiet_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset scaling: all-equal window at both ends, field extremes
		push_sample(0);
		push_sample(1023);
		push_sample(0);
		push_sample(512);
		push_sample(1);
		push_sample(1022);
		repeat (8) push_sample(1023);
		wait_drain();
		// zero ADC span
		set_scaling(300, 300, -5, 5);
		push_sample(300);
		push_sample(7);
		wait_drain();
		// one-count span, full value range: saturation
		set_scaling(0, 1, -32768, 32767);
		push_sample(0);
		push_sample(1023);
		wait_drain();
		// reversed spans
		set_scaling(1023, 0, 32767, -32768);
		push_sample(1023);
		push_sample(0);
		push_sample(511);
		wait_drain();

		for (int p = 0; p < 12; p++) begin
			random_scaling(p < 6 ? p : $urandom_range(0, 5));
			base = $urandom_range(0, 1023);
			last = base;
			for (int n = 0; n < 158; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						v = base + int'($urandom_range(0, 16)) - 8;
						if (v < 0)
							v = 0;
						if (v > 1023)
							v = 1023;
					end
					4, 5: v = $urandom_range(0, 1023);
					6: v = 0;
					7: v = 1023;
					8: v = last;
					default: v = base;
				endcase
				last = v;
				push_sample(v);
			end
			wait_drain();
		end

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
design/tmss_pkg.sv
design/tmss_div.sv
design/trimmed_mean_sensor_scaler_top.sv
test/tb_top.sv
